// ----- sv/b32he_pkg.sv -----
// Shared types, constants and the base32 alphabet lookup for the hostname encoder.
`default_nettype none

package b32he_pkg;

    // Most results one input beat can cause: two characters, a flush, one dot.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [6:0] DOT_CHAR        = 7'h2E;
    localparam logic [7:0] MAX_INPUT_RESET = 8'd153;
    localparam logic [7:0] BYTES_SAT       = 8'd255;

    // Register word index on the configuration port.
    localparam logic REG_MAX_INPUT_BYTES = 1'b0;

    typedef struct packed {
        logic [3:0] leftover_bits;
        logic [2:0] leftover_count;
        logic [5:0] label_position;
        logic [7:0] bytes_seen;
        logic       overflow_flag;
    } t_state;

    typedef struct packed {
        logic [6:0] symbol;
        logic       symbol_valid;
        logic       run_end;
        logic       message_end;
        logic       too_long;
    } t_result;

    typedef t_result [MAX_RESULTS-1:0] t_result_set;

    // Letters A..Z for groups 0..25, digits 2..7 for groups 26..31.
    function automatic logic [6:0] b32_char(input logic [4:0] grp);
        logic [6:0] ch;
        if (grp < 5'd26) begin
            ch = 7'h41 + {2'b00, grp};
        end else begin
            ch = 7'h18 + {2'b00, grp};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/b32he_encode.sv -----
// Encodes one byte against the current message state into a set of up to four results.
`default_nettype none

module b32he_encode (
    input  wire logic [7:0]                 i_byte_value,
    input  wire logic                       i_last_byte,
    input  wire b32he_pkg::t_state          i_state,
    input  wire logic [7:0]                 i_max_input_bytes,
    output b32he_pkg::t_result_set          o_results,
    output logic [b32he_pkg::CNT_W-1:0]     o_count,
    output b32he_pkg::t_state               o_state
);

    logic       ovf_now;
    logic [7:0] bytes_next;
    logic [4:0] grp0;
    logic [4:0] grp1;
    logic [4:0] grp_fl;
    logic       two;
    logic [2:0] left;
    logic [3:0] lbits;
    logic       flush;
    logic [4:0] grp [3];
    logic [2:0] nchar;
    logic [5:0] pos;
    logic [b32he_pkg::CNT_W-1:0] k;
    b32he_pkg::t_result_set res;

    // A message goes too long once the byte count would pass the limit; it stays so.
    assign ovf_now = i_state.overflow_flag || (i_state.bytes_seen >= i_max_input_bytes);

    always_comb begin
        if (!i_state.overflow_flag && (i_state.bytes_seen != b32he_pkg::BYTES_SAT)) begin
            bytes_next = i_state.bytes_seen + 8'd1;
        end else begin
            bytes_next = i_state.bytes_seen;
        end
    end

    // Split the pending bits plus the new byte into 5-bit groups, MSB first.
    always_comb begin
        grp1 = '0;
        unique case (i_state.leftover_count)
            3'd0: begin
                grp0   = i_byte_value[7:3];
                two    = 1'b0;
                left   = 3'd3;
                lbits  = {1'b0, i_byte_value[2:0]};
                grp_fl = {i_byte_value[2:0], 2'b00};
            end
            3'd1: begin
                grp0   = {i_state.leftover_bits[0], i_byte_value[7:4]};
                two    = 1'b0;
                left   = 3'd4;
                lbits  = i_byte_value[3:0];
                grp_fl = {i_byte_value[3:0], 1'b0};
            end
            3'd2: begin
                grp0   = {i_state.leftover_bits[1:0], i_byte_value[7:5]};
                grp1   = i_byte_value[4:0];
                two    = 1'b1;
                left   = 3'd0;
                lbits  = 4'd0;
                grp_fl = 5'd0;
            end
            3'd3: begin
                grp0   = {i_state.leftover_bits[2:0], i_byte_value[7:6]};
                grp1   = i_byte_value[5:1];
                two    = 1'b1;
                left   = 3'd1;
                lbits  = {3'b000, i_byte_value[0]};
                grp_fl = {i_byte_value[0], 4'b0000};
            end
            default: begin
                grp0   = {i_state.leftover_bits[3:0], i_byte_value[7]};
                grp1   = i_byte_value[6:2];
                two    = 1'b1;
                left   = 3'd2;
                lbits  = {2'b00, i_byte_value[1:0]};
                grp_fl = {i_byte_value[1:0], 3'b000};
            end
        endcase
    end

    assign flush = i_last_byte && (left != 3'd0);

    always_comb begin
        grp[0] = grp0;
        if (two) begin
            grp[1] = grp1;
            grp[2] = grp_fl;
        end else begin
            grp[1] = grp_fl;
            grp[2] = 5'd0;
        end
        nchar = 3'd1 + {2'b00, two} + {2'b00, flush};
    end

    // Place characters in order; a dot goes in front of every character whose
    // position count wraps to zero.
    always_comb begin
        pos = i_state.label_position;
        k   = '0;
        res = '0;
        if (ovf_now) begin
            res[0].too_long = 1'b1;
            k = b32he_pkg::CNT_W'(1);
        end else begin
            for (int c = 0; c < 3; c++) begin
                if (3'(c) < nchar) begin
                    pos = pos + 6'd1;
                    if (pos == 6'd0) begin
                        res[k[1:0]].symbol       = b32he_pkg::DOT_CHAR;
                        res[k[1:0]].symbol_valid = 1'b1;
                        k   = k + b32he_pkg::CNT_W'(1);
                        pos = 6'd1;
                    end
                    res[k[1:0]].symbol       = b32he_pkg::b32_char(grp[c]);
                    res[k[1:0]].symbol_valid = 1'b1;
                    k = k + b32he_pkg::CNT_W'(1);
                end
            end
        end
        for (int i = 0; i < b32he_pkg::MAX_RESULTS; i++) begin
            if (b32he_pkg::CNT_W'(i) == (k - b32he_pkg::CNT_W'(1))) begin
                res[i].run_end     = 1'b1;
                res[i].message_end = i_last_byte;
            end
        end
    end

    always_comb begin
        if (i_last_byte) begin
            o_state = '0;
        end else if (ovf_now) begin
            o_state               = i_state;
            o_state.bytes_seen    = bytes_next;
            o_state.overflow_flag = 1'b1;
        end else begin
            o_state.leftover_bits  = lbits;
            o_state.leftover_count = left;
            o_state.label_position = pos;
            o_state.bytes_seen     = bytes_next;
            o_state.overflow_flag  = 1'b0;
        end
    end

    assign o_results = res;
    assign o_count   = k;

endmodule

`default_nettype wire

// ----- sv/base32_hostname_encoder.sv -----
// Streaming unpadded base32 encoder that splits its output into dotted hostname labels.
//
// Input channel: one message byte per beat (i_byte_value, i_last_byte), taken when
// i_in_valid is high and o_in_stall is low. Output channel: one result per beat
// (character or too-long status, with run_end and message_end marks), delivered
// when o_out_valid is high and i_out_stall is low. max_input_bytes is written over
// the APB port at byte address 0; reads return it, pready is always high.
// The first result of a byte passes the input register, then the result buffer,
// before it reaches the output. Each byte causes one to four results and the
// output moves one result per cycle while i_out_stall is low; the next byte is
// loaded in the cycle its predecessor's last result leaves, giving one byte per
// cycle for single results when the receiver does not stall.
// When the receiver stalls, the result buffer holds and the input register fills,
// after which o_in_stall rises. Reset empties both, clears the message state and
// sets max_input_bytes to 153.
`default_nettype none

module base32_hostname_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [6:0]       o_symbol,
    output logic             o_symbol_valid,
    output logic             o_run_end,
    output logic             o_message_end,
    output logic             o_too_long,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                           r_in_valid;
    logic                           n_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_in_last;
    b32he_pkg::t_state              r_state;
    logic [7:0]                     r_max;
    b32he_pkg::t_result_set         r_buf;
    b32he_pkg::t_result_set         n_buf;
    logic [b32he_pkg::CNT_W-1:0]    r_cnt;
    logic [b32he_pkg::CNT_W-1:0]    n_cnt;

    b32he_pkg::t_result_set         enc_results;
    logic [b32he_pkg::CNT_W-1:0]    enc_count;
    b32he_pkg::t_state              enc_state;

    logic in_take;
    logic out_take;
    logic buf_free;
    logic load;
    logic cfg_wr;

    b32he_encode u_encode (
        .i_byte_value      (r_in_byte),
        .i_last_byte       (r_in_last),
        .i_state           (r_state),
        .i_max_input_bytes (r_max),
        .o_results         (enc_results),
        .o_count           (enc_count),
        .o_state           (enc_state)
    );

    assign out_take = o_out_valid && !i_out_stall;
    // The buffer can take a new byte's results when it is empty or its last entry leaves now.
    assign buf_free = (r_cnt == '0) || ((r_cnt == b32he_pkg::CNT_W'(1)) && out_take);
    assign load     = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !load;
    assign in_take  = i_in_valid && !o_in_stall;

    always_comb begin
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (load) begin
            n_buf = enc_results;
            n_cnt = enc_count;
        end else if (out_take) begin
            for (int i = 0; i < b32he_pkg::MAX_RESULTS - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_buf[b32he_pkg::MAX_RESULTS-1] = '0;
            n_cnt = r_cnt - b32he_pkg::CNT_W'(1);
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == b32he_pkg::REG_MAX_INPUT_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_max      <= b32he_pkg::MAX_INPUT_RESET;
            r_cnt      <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            if (load) begin
                r_state <= enc_state;
            end
            if (cfg_wr) begin
                r_max <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
        r_buf <= n_buf;
    end

    assign o_out_valid    = (r_cnt != '0);
    assign o_symbol       = r_buf[0].symbol;
    assign o_symbol_valid = r_buf[0].symbol_valid;
    assign o_run_end      = r_buf[0].run_end;
    assign o_message_end  = r_buf[0].message_end;
    assign o_too_long     = r_buf[0].too_long;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == b32he_pkg::REG_MAX_INPUT_BYTES) ? {24'd0, r_max} : 32'd0;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= b32he_pkg::CNT_W'(b32he_pkg::MAX_RESULTS))
        else $error("result buffer count out of range");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_end) |-> (r_cnt >= b32he_pkg::CNT_W'(2)))
        else $error("byte's results end without a run_end mark");

    a_msg_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_end) |-> o_run_end)
        else $error("message_end without run_end");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_last) |=> (r_state == '0))
        else $error("message state not cleared after last byte");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the base32 hostname encoder: stream stimulus, predictor and checker.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MAX_BYTES = {b32he_pkg::REG_MAX_INPUT_BYTES, 2'b00};
    localparam int SETTLE_CYCLES = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_symbol;
    logic        o_symbol_valid;
    logic        o_run_end;
    logic        o_message_end;
    logic        o_too_long;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    base32_hostname_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_run_end      (o_run_end),
        .o_message_end  (o_message_end),
        .o_too_long     (o_too_long),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    // Encoder state as predicted, plus the configured byte limit.
    logic [7:0] limit_bytes;
    logic [3:0] pend_bits;
    logic [2:0] pend_cnt;
    logic [5:0] label_pos;
    logic [7:0] msg_bytes;
    logic       msg_over;

    b32he_pkg::t_result expected_symbols[$];
    b32he_pkg::t_result beat_res[b32he_pkg::MAX_RESULTS];
    int      beat_cnt;
    int      n_errors = 0;

    // Traffic shaping knobs, set by the tests.
    int send_gap_max = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int hold_req = 0;

    function automatic logic [6:0] group_to_ascii(input logic [4:0] g);
        logic [7:0] a;
        if (g < 5'd26) begin
            a = 8'h41 + {3'b000, g};
        end else begin
            a = 8'h32 + {3'b000, g} - 8'd26;
        end
        return a[6:0];
    endfunction

    function automatic void stage_result(input logic [6:0] s, input logic v, input logic tl);
        b32he_pkg::t_result r;
        r.symbol       = s;
        r.symbol_valid = v;
        r.run_end      = 1'b0;
        r.message_end  = 1'b0;
        r.too_long     = tl;
        beat_res[beat_cnt] = r;
        beat_cnt++;
    endfunction

    function automatic void stage_char(input logic [4:0] g);
        label_pos = label_pos + 6'd1;
        if (label_pos == 6'd0) begin
            stage_result(b32he_pkg::DOT_CHAR, 1'b1, 1'b0);
            label_pos = 6'd1;
        end
        stage_result(group_to_ascii(g), 1'b1, 1'b0);
    endfunction

    function automatic void clear_message_state();
        pend_bits = 4'd0;
        pend_cnt  = 3'd0;
        label_pos = 6'd0;
        msg_bytes = 8'd0;
        msg_over  = 1'b0;
    endfunction

    // Works out the symbols one accepted byte causes and queues them.
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic [11:0] bits;
        logic [4:0]  flush_grp;
        int          total;
        b32he_pkg::t_result r;
        beat_cnt = 0;
        if (!msg_over) begin
            if ({1'b0, msg_bytes} + 9'd1 > {1'b0, limit_bytes}) msg_over = 1'b1;
            if (msg_bytes != b32he_pkg::BYTES_SAT) msg_bytes = msg_bytes + 8'd1;
        end
        if (msg_over) begin
            stage_result(7'd0, 1'b0, 1'b1);
        end else begin
            bits  = {pend_bits, b};
            total = int'(pend_cnt) + 8;
            if (total > 12) total = 12;
            while (total >= 5) begin
                stage_char(5'((bits >> (total - 5)) & 12'h1F));
                total -= 5;
            end
            pend_bits = 4'(bits & ((12'd1 << total) - 12'd1));
            pend_cnt  = 3'(total);
            if (last && pend_cnt != 3'd0) begin
                flush_grp = 5'({1'b0, pend_bits} << (3'd5 - pend_cnt));
                stage_char(flush_grp);
            end
        end
        r = beat_res[beat_cnt-1];
        r.run_end = 1'b1;
        if (last) r.message_end = 1'b1;
        beat_res[beat_cnt-1] = r;
        if (last) clear_message_state();
        for (int i = 0; i < beat_cnt; i++) expected_symbols.push_back(beat_res[i]);
    endfunction

    task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Output checker: every beat that leaves the block is matched with the oldest prediction.
    always @(posedge i_clk) begin
        b32he_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_symbols.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got symbol %0h", $time, o_symbol);
                n_errors++;
            end else begin
                want = expected_symbols.pop_front();
                check_field("symbol", want.symbol, o_symbol);
                check_field("symbol_valid", 7'(want.symbol_valid), 7'(o_symbol_valid));
                check_field("run_end", 7'(want.run_end), 7'(o_run_end));
                check_field("message_end", 7'(want.message_end), 7'(o_message_end));
                check_field("too_long", 7'(want.too_long), 7'(o_too_long));
            end
        end
    end

    // Receiver: stalls in random runs, or holds off for a requested number of cycles.
    initial begin : receiver
        int hold_left;
        int run_left;
        logic level;
        hold_left = 0;
        run_left  = 0;
        level     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                if (run_left == 0) begin
                    level    = (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
                    run_left = $urandom_range(1, 4);
                end
                run_left--;
                i_out_stall <= level;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge i_clk);
        if (send_gap_max > 0 && burst_left == 0) begin
            gap        = $urandom_range(1, send_gap_max);
            burst_left = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        do @(posedge i_clk); while (o_in_stall);
        encode_byte(b, last);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Stops offering beats and waits until every predicted symbol has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limit(input logic [7:0] lim);
        drain();
        apb_write(ADDR_MAX_BYTES, {24'd0, lim});
        limit_bytes = lim;
    endtask

    task automatic check_limit_readback();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_BYTES;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("max_input_bytes", 7'(limit_bytes), 7'(prdata[7:0]));
        if (prdata[7] !== limit_bytes[7]) begin
            $display("%0t: max_input_bytes mismatch, expected %0h, got %0h",
                     $time, limit_bytes, prdata[7:0]);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Single-byte messages at the field extremes, an exact five-byte group and a flush.
    task automatic test_directed();
        check_limit_readback();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();
    endtask

    // A one-byte limit drops leftover bits; a zero limit rejects every byte.
    task automatic test_limits();
        set_limit(8'd1);
        check_limit_readback();
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_limit(8'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        drain();
    endtask

    // A long message crosses a label boundary and then runs past the limit.
    task automatic test_labels();
        set_limit(8'd45);
        check_limit_readback();
        send_gap_max = 3;
        stall_pct    = 30;
        send_message(50);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipeline.
    task automatic test_backpressure();
        set_limit(8'd153);
        send_gap_max = 0;
        stall_pct    = 0;
        hold_req     = 300;
        send_message(6);
        send_message(8);
        drain();
    endtask

    task automatic test_random();
        logic [7:0] lims[4];
        int len;
        int sent;
        lims[0] = 8'($urandom_range(1, 255));
        lims[1] = 8'd3;
        lims[2] = 8'd255;
        lims[3] = 8'd12;
        for (int p = 0; p < 4; p++) begin
            set_limit(lims[p]);
            send_gap_max = (p == 2) ? 0 : 4;
            stall_pct    = (p == 1) ? 0 : 20 + 15 * p;
            sent = 0;
            while (sent < 6) begin
                if ($urandom_range(0, 9) < 8) len = $urandom_range(1, 4);
                else len = $urandom_range(5, 10);
                send_message(len);
                sent += len;
            end
        end
        set_limit(8'd153);
        drain();
    endtask

    initial begin : main
        limit_bytes = b32he_pkg::MAX_INPUT_RESET;
        clear_message_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_limits();
        test_labels();
        test_backpressure();
        test_random();
        drain();
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/b32he_pkg.sv
sv/b32he_encode.sv
sv/base32_hostname_encoder.sv
dv/tb.sv
